// ===== rtl/mpps_pkg.sv =====
// Shared types, constants and the saturating helper of the magnetic pointer position solver.
package mpps_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int CORNER_BITS   = 3 * SAMPLE_BITS;
  localparam int Q_BITS        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SAT_BITS      = 72;
  localparam int CFG_IDX_BITS  = 2;
  localparam int POS_BITS      = 16;
  localparam int POS_SHIFT     = 15;   // 32767 = 2^15 - 1

  localparam logic [CFG_IDX_BITS-1:0] REG_TOP_LEFT     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP_RIGHT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM_LEFT  = 2'd2;

  localparam logic [2:0] BUTTON_MASK = 3'h7;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
    logic                          sample_valid;
    logic                          sensor_overflow;
    logic [2:0]                    button_bits;
    logic                          recent_click;
  } in_word_t;

  typedef struct packed {
    logic                       send_report;
    logic [2:0]                 buttons_out;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
  } out_word_t;

  typedef struct packed {
    logic done;
    logic ok;
  } sol_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SOLVE,
    ST_SMOOTH,
    ST_EMIT
  } top_state_t;

  typedef enum logic [3:0] {
    SS_IDLE,
    SS_PIV,
    SS_PCHK,
    SS_SWA,
    SS_SWB,
    SS_SWC,
    SS_DNUM,
    SS_DDEN,
    SS_DWAIT,
    SS_MUL,
    SS_SUB,
    SS_RANGE,
    SS_DONE
  } sol_state_t;

  typedef enum logic [1:0] {
    PH_ELIM,
    PH_SV,
    PH_SU
  } phase_t;

  // Clamp a wide signed value into the signed Q range.
  function automatic logic signed [Q_BITS-1:0] sat_q(input logic signed [SAT_BITS-1:0] v);
    logic signed [SAT_BITS-1:0] qmax;
    logic signed [SAT_BITS-1:0] qmin;
    qmax = {{(SAT_BITS-Q_BITS+1){1'b0}}, {(Q_BITS-1){1'b1}}};
    qmin = {{(SAT_BITS-Q_BITS+1){1'b1}}, {(Q_BITS-1){1'b0}}};
    if (v > qmax) begin
      sat_q = qmax[Q_BITS-1:0];
    end else if (v < qmin) begin
      sat_q = qmin[Q_BITS-1:0];
    end else begin
      sat_q = v[Q_BITS-1:0];
    end
  endfunction

endpackage

// ===== rtl/mpps_div.sv =====
// Restoring radix-2 divider: saturated Q quotient (num * 2^FRAC_BITS) / den, toward zero.
module mpps_div import mpps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [Q_BITS-1:0] num,
  input  logic signed [Q_BITS-1:0] den,
  output logic                     done,
  output logic signed [Q_BITS-1:0] quot
);

  localparam int DIV_BITS = Q_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0] dvd;
  logic [Q_BITS-1:0]   rem;
  logic [Q_BITS-1:0]   dsr;
  logic [DIV_BITS-1:0] quo;
  logic                neg;
  logic                zero;

  logic [Q_BITS-1:0]          num_mag;
  logic [Q_BITS-1:0]          den_mag;
  logic [Q_BITS:0]            trial;
  logic                       take;
  logic signed [SAT_BITS-1:0] wide_q;

  always_comb begin
    num_mag = num[Q_BITS-1] ? Q_BITS'(-num) : Q_BITS'(num);
    den_mag = den[Q_BITS-1] ? Q_BITS'(-den) : Q_BITS'(den);
    trial   = {rem, dvd[DIV_BITS-1]};
    take    = (trial >= {1'b0, dsr});
    wide_q  = {{(SAT_BITS-DIV_BITS){1'b0}}, quo};
    if (neg) begin
      wide_q = -wide_q;
    end
    quot = zero ? '0 : sat_q(wide_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {num_mag, {FRAC_BITS{1'b0}}};
      dsr  <= den_mag;
      rem  <= '0;
      quo  <= '0;
      neg  <= num[Q_BITS-1] ^ den[Q_BITS-1];
      zero <= (den == '0);
    end else if (busy) begin
      dvd <= {dvd[DIV_BITS-2:0], 1'b0};
      quo <= {quo[DIV_BITS-2:0], take};
      rem <= take ? Q_BITS'(trial - {1'b0, dsr}) : trial[Q_BITS-1:0];
    end
  end

endmodule

// ===== rtl/mpps_solver.sv =====
// Sequenced Gaussian elimination with partial pivoting over a 3x4 Q matrix, one entry at a time.
module mpps_solver import mpps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] px,
  input  logic signed [SAMPLE_BITS-1:0] py,
  input  logic signed [SAMPLE_BITS-1:0] pz,
  input  logic [CORNER_BITS-1:0]        corner_a,
  input  logic [CORNER_BITS-1:0]        corner_b,
  input  logic [CORNER_BITS-1:0]        corner_c,
  output sol_stat_t                     stat,
  output logic signed [Q_BITS-1:0]      su,
  output logic signed [Q_BITS-1:0]      sv
);

  localparam logic [Q_BITS:0]            THR = (Q_BITS+1)'(2 ** (FRAC_BITS - 10));
  localparam logic signed [Q_BITS-1:0]   LO  = Q_BITS'(-(2 ** (FRAC_BITS - 2)));
  localparam logic signed [Q_BITS-1:0]   HI  = Q_BITS'(5 * (2 ** (FRAC_BITS - 2)));
  localparam logic signed [2*Q_BITS-1:0] RND =
    {{(2*Q_BITS-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  sol_state_t state;
  sol_state_t state_next;
  phase_t     phase;

  logic signed [Q_BITS-1:0]   m [3][4];
  logic signed [Q_BITS-1:0]   init_m [3][4];
  logic signed [SAMPLE_BITS-1:0] pv [3];

  logic [1:0] k;
  logic [1:0] r2;
  logic [1:0] c;
  logic [1:0] i;
  logic [1:0] bi;
  logic [Q_BITS:0]            best;
  logic signed [Q_BITS-1:0]   tmp;
  logic signed [Q_BITS-1:0]   f;
  logic signed [Q_BITS-1:0]   dnum;
  logic signed [2*Q_BITS-1:0] prod;
  logic                       ok;

  logic [1:0]                 rd_r;
  logic [1:0]                 rd_c;
  logic signed [Q_BITS-1:0]   rd;
  logic [Q_BITS:0]            rd_abs;
  logic signed [Q_BITS:0]     rd_ext;
  logic                       wr_en;
  logic [1:0]                 wr_r;
  logic [1:0]                 wr_c;
  logic signed [Q_BITS-1:0]   wr_data;
  logic signed [2*Q_BITS-1:0] adj;
  logic signed [Q_BITS-1:0]   mq;
  logic signed [Q_BITS-1:0]   diff;
  logic                       div_start;
  logic                       div_done;
  logic signed [Q_BITS-1:0]   div_q;

  mpps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   (rd),
    .done  (div_done),
    .quot  (div_q)
  );

  assign pv[0] = px;
  assign pv[1] = py;
  assign pv[2] = pz;

  // Build the augmented matrix [-P | B-A | C-A | -A], scaled to Q.
  always_comb begin
    logic signed [SAT_BITS-1:0] a_w;
    logic signed [SAT_BITS-1:0] b_w;
    logic signed [SAT_BITS-1:0] c_w;
    logic signed [SAT_BITS-1:0] p_w;
    for (int r = 0; r < 3; r++) begin
      a_w = SAT_BITS'($signed(corner_a[r*SAMPLE_BITS +: SAMPLE_BITS]));
      b_w = SAT_BITS'($signed(corner_b[r*SAMPLE_BITS +: SAMPLE_BITS]));
      c_w = SAT_BITS'($signed(corner_c[r*SAMPLE_BITS +: SAMPLE_BITS]));
      p_w = SAT_BITS'(pv[r]);
      init_m[r][0] = sat_q((-p_w) <<< FRAC_BITS);
      init_m[r][1] = sat_q((b_w - a_w) <<< FRAC_BITS);
      init_m[r][2] = sat_q((c_w - a_w) <<< FRAC_BITS);
      init_m[r][3] = sat_q((-a_w) <<< FRAC_BITS);
    end
  end

  // Single read port address.
  always_comb begin
    rd_r = 2'd0;
    rd_c = 2'd0;
    case (state)
      SS_PIV: begin
        rd_r = i;
        rd_c = k;
      end
      SS_SWA: begin
        rd_r = k;
        rd_c = c;
      end
      SS_SWB: begin
        rd_r = bi;
        rd_c = c;
      end
      SS_DNUM: begin
        case (phase)
          PH_ELIM: begin
            rd_r = r2;
            rd_c = k;
          end
          PH_SV: begin
            rd_r = 2'd2;
            rd_c = 2'd3;
          end
          default: begin
            rd_r = 2'd1;
            rd_c = 2'd3;
          end
        endcase
      end
      SS_DDEN, SS_DWAIT: begin
        case (phase)
          PH_ELIM: begin
            rd_r = k;
            rd_c = k;
          end
          PH_SV: begin
            rd_r = 2'd2;
            rd_c = 2'd2;
          end
          default: begin
            rd_r = 2'd1;
            rd_c = 2'd1;
          end
        endcase
      end
      SS_MUL: begin
        if (phase == PH_ELIM) begin
          rd_r = k;
          rd_c = c;
        end else begin
          rd_r = 2'd1;
          rd_c = 2'd2;
        end
      end
      SS_SUB: begin
        if (phase == PH_ELIM) begin
          rd_r = r2;
          rd_c = c;
        end else begin
          rd_r = 2'd1;
          rd_c = 2'd3;
        end
      end
      default: begin
        rd_r = 2'd0;
        rd_c = 2'd0;
      end
    endcase
  end

  // Shared arithmetic: magnitude, truncating product scale and saturating subtract.
  always_comb begin
    rd     = m[rd_r][rd_c];
    rd_ext = {rd[Q_BITS-1], rd};
    rd_abs = rd_ext[Q_BITS] ? (Q_BITS+1)'(-rd_ext) : (Q_BITS+1)'(rd_ext);
    adj    = prod[2*Q_BITS-1] ? prod + RND : prod;
    mq     = sat_q(SAT_BITS'(adj >>> FRAC_BITS));
    diff   = sat_q(SAT_BITS'(rd) - SAT_BITS'(mq));
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      SS_IDLE: begin
        if (start) begin
          state_next = SS_PIV;
        end
      end
      SS_PIV: begin
        if (i == 2'd2) begin
          state_next = SS_PCHK;
        end
      end
      SS_PCHK: begin
        if (best < THR) begin
          state_next = SS_DONE;
        end else if (k == 2'd2 || bi == k) begin
          state_next = SS_DNUM;
        end else begin
          state_next = SS_SWA;
        end
      end
      SS_SWA:  state_next = SS_SWB;
      SS_SWB:  state_next = SS_SWC;
      SS_SWC:  state_next = (c == 2'd3) ? SS_DNUM : SS_SWA;
      SS_DNUM: state_next = SS_DDEN;
      SS_DDEN: state_next = SS_DWAIT;
      SS_DWAIT: begin
        if (div_done) begin
          state_next = (phase == PH_SU) ? SS_RANGE : SS_MUL;
        end
      end
      SS_MUL:  state_next = SS_SUB;
      SS_SUB: begin
        if (phase != PH_ELIM) begin
          state_next = SS_DNUM;
        end else if (c != 2'd3) begin
          state_next = SS_MUL;
        end else if (r2 == 2'd2) begin
          state_next = SS_PIV;
        end else begin
          state_next = SS_DNUM;
        end
      end
      SS_RANGE: state_next = SS_DONE;
      SS_DONE:  state_next = SS_IDLE;
      default:  state_next = SS_IDLE;
    endcase
  end

  // Write port and divider launch.
  always_comb begin
    wr_en     = 1'b0;
    wr_r      = 2'd0;
    wr_c      = 2'd0;
    wr_data   = rd;
    div_start = 1'b0;
    case (state)
      SS_SWB: begin
        wr_en   = 1'b1;
        wr_r    = k;
        wr_c    = c;
        wr_data = rd;
      end
      SS_SWC: begin
        wr_en   = 1'b1;
        wr_r    = bi;
        wr_c    = c;
        wr_data = tmp;
      end
      SS_SUB: begin
        wr_en   = 1'b1;
        wr_r    = (phase == PH_ELIM) ? r2 : 2'd1;
        wr_c    = (phase == PH_ELIM) ? c : 2'd3;
        wr_data = diff;
      end
      SS_DDEN: div_start = 1'b1;
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters and datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      SS_IDLE: begin
        k     <= 2'd0;
        i     <= 2'd0;
        phase <= PH_ELIM;
      end
      SS_PIV: begin
        if (i == k || rd_abs > best) begin
          best <= rd_abs;
          bi   <= i;
        end
        if (i != 2'd2) begin
          i <= i + 2'd1;
        end
      end
      SS_PCHK: begin
        c  <= k;
        r2 <= k + 2'd1;
        if (best < THR) begin
          ok <= 1'b0;
        end
        if (k == 2'd2) begin
          phase <= PH_SV;
        end
      end
      SS_SWA: tmp <= rd;
      SS_SWC: begin
        if (c != 2'd3) begin
          c <= c + 2'd1;
        end
      end
      SS_DNUM: dnum <= rd;
      SS_DWAIT: begin
        if (div_done) begin
          f <= div_q;
          c <= k + 2'd1;
          case (phase)
            PH_SV: begin
              sv    <= div_q;
              phase <= PH_SU;
            end
            PH_SU: su <= div_q;
            default: begin
              f <= div_q;
            end
          endcase
        end
      end
      SS_MUL: prod <= rd * f;
      SS_SUB: begin
        if (phase == PH_ELIM) begin
          if (c != 2'd3) begin
            c <= c + 2'd1;
          end else if (r2 == 2'd2) begin
            k <= k + 2'd1;
            i <= k + 2'd1;
          end else begin
            r2 <= r2 + 2'd1;
          end
        end
      end
      SS_RANGE: ok <= !(su < LO || su > HI || sv < LO || sv > HI);
      default: begin
        tmp <= tmp;
      end
    endcase
  end

  // Matrix: whole load on start, then one entry per cycle while the write port is enabled.
  always_ff @(posedge clk) begin
    if (state == SS_IDLE && start) begin
      m <= init_m;
    end else if (wr_en) begin
      m[wr_r][wr_c] <= wr_data;
    end
  end

  assign stat.done = (state == SS_DONE);
  assign stat.ok   = ok;

endmodule

// ===== rtl/magnetic_pointer_position_solver_core.sv =====
// Top level of the magnetic pointer position solver: handshake, button report and smoothing.
//
// Usage:
//   Input words arrive on in_valid/in_ready/in_word; one report word leaves per input word
//   on out_valid/out_ready/out_word. The three corner vectors are written through
//   cfg_we/cfg_index/cfg_data while the block is idle; index 3 is ignored.
//   A word that only updates the buttons (recent click, no sample or overflow) goes
//   straight to the emit state, which loads the report and raises out_valid. A word that
//   needs a position solve runs the elimination sequencer: five divisions in the shared
//   divider, plus pivot search, row swaps and multiply-subtract steps on one entry at a time.
//   One word is in work at a time; in_ready is high only while the sequencer is idle.
//   The report sits in an output register, so a new word is taken while a report waits;
//   when the receiver stalls, a finished report waits in the emit state until the register
//   frees up, and the block accepts nothing in the meantime.
//   Reset clears the corners to zero, the buttons to zero, the position to -1 and the
//   smoothing state to zero; there is no clearing pass.
module magnetic_pointer_position_solver_core import mpps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_word_t                in_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_word_t               out_word,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CORNER_BITS-1:0]  cfg_data
);

  localparam int SUM_BITS = Q_BITS + 3;
  localparam int SCL_BITS = FRAC_BITS + POS_SHIFT + 2;
  localparam logic signed [SUM_BITS-1:0] ONE_W =
    {{(SUM_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SCL_BITS-1:0] HALF = SCL_BITS'(2 ** (FRAC_BITS - 1));

  top_state_t state;
  top_state_t state_next;

  logic [CORNER_BITS-1:0]     corner_a;
  logic [CORNER_BITS-1:0]     corner_b;
  logic [CORNER_BITS-1:0]     corner_c;
  logic [2:0]                 held_buttons;
  logic signed [POS_BITS-1:0] report_x;
  logic signed [POS_BITS-1:0] report_y;
  logic [FRAC_BITS:0]         smooth_x;
  logic [FRAC_BITS:0]         smooth_y;
  logic                       send;

  logic                       accept;
  logic                       do_solve;
  logic                       sol_start;
  logic                       emit;
  sol_stat_t                  sol_stat;
  logic signed [Q_BITS-1:0]   su;
  logic signed [Q_BITS-1:0]   sv;

  logic [FRAC_BITS:0]         smooth_x_next;
  logic [FRAC_BITS:0]         smooth_y_next;
  logic [POS_BITS-1:0]        report_x_next;
  logic [POS_BITS-1:0]        report_y_next;

  mpps_solver #(.FRAC_BITS(FRAC_BITS)) u_solver (
    .clk      (clk),
    .rst      (rst),
    .start    (sol_start),
    .px       (in_word.sample_x),
    .py       (in_word.sample_y),
    .pz       (in_word.sample_z),
    .corner_a (corner_a),
    .corner_b (corner_b),
    .corner_c (corner_c),
    .stat     (sol_stat),
    .su       (su),
    .sv       (sv)
  );

  // Exponential smoothing with alpha 1/8, clamp to 0..1, scale by 32767 with rounding.
  function automatic logic [FRAC_BITS:0] smooth_fn(input logic [FRAC_BITS:0] s,
                                                   input logic signed [Q_BITS-1:0] sol);
    logic signed [SUM_BITS-1:0] s_w;
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS-1:0] sh;
    s_w = $signed({{(SUM_BITS-FRAC_BITS-1){1'b0}}, s});
    sum = (s_w <<< 3) - s_w + SUM_BITS'(sol);
    sh  = sum >>> 3;
    if (sum[SUM_BITS-1]) begin
      smooth_fn = '0;
    end else if (sh > ONE_W) begin
      smooth_fn = ONE_W[FRAC_BITS:0];
    end else begin
      smooth_fn = sh[FRAC_BITS:0];
    end
  endfunction

  function automatic logic [POS_BITS-1:0] scale_fn(input logic [FRAC_BITS:0] a);
    logic [SCL_BITS-1:0] a_w;
    logic [SCL_BITS-1:0] sc;
    a_w = SCL_BITS'(a);
    sc  = (a_w << POS_SHIFT) - a_w + HALF;
    scale_fn = sc[FRAC_BITS +: POS_BITS];
  endfunction

  always_comb begin
    smooth_x_next = smooth_fn(smooth_x, su);
    smooth_y_next = smooth_fn(smooth_y, sv);
    report_x_next = scale_fn(smooth_x_next);
    report_y_next = scale_fn(smooth_y_next);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = do_solve ? ST_SOLVE : ST_EMIT;
        end
      end
      ST_SOLVE: begin
        if (sol_stat.done) begin
          state_next = sol_stat.ok ? ST_SMOOTH : ST_EMIT;
        end
      end
      ST_SMOOTH: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and launch strobes.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    accept    = in_valid && in_ready;
    do_solve  = !in_word.recent_click && in_word.sample_valid && !in_word.sensor_overflow;
    sol_start = accept && do_solve;
    emit      = (state == ST_EMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Corner registers; the sequencer samples them only at launch, so write them while idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a <= '0;
      corner_b <= '0;
      corner_c <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOP_LEFT:    corner_a <= cfg_data;
        REG_TOP_RIGHT:   corner_b <= cfg_data;
        REG_BOTTOM_LEFT: corner_c <= cfg_data;
        default: begin
          corner_a <= corner_a;
        end
      endcase
    end
  end

  // Report state: buttons on accept, position after a good solve.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_buttons <= '0;
      report_x     <= '1;
      report_y     <= '1;
      smooth_x     <= '0;
      smooth_y     <= '0;
      send         <= 1'b0;
    end else begin
      if (accept) begin
        held_buttons <= in_word.button_bits & BUTTON_MASK;
        send         <= ((in_word.button_bits & BUTTON_MASK) != held_buttons);
      end
      if (state == ST_SMOOTH) begin
        smooth_x <= smooth_x_next;
        smooth_y <= smooth_y_next;
        report_x <= $signed(report_x_next);
        report_y <= $signed(report_y_next);
        send     <= 1'b1;
      end
    end
  end

  // Output register: load on emit, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word.send_report <= send;
      out_word.buttons_out <= held_buttons;
      out_word.pos_x       <= report_x;
      out_word.pos_y       <= report_y;
    end
  end

  // The solver only finishes while a solve is outstanding.
  a_done_in_solve: assert property (@(posedge clk) disable iff (rst)
    sol_stat.done |-> state == ST_SOLVE)
    else $error("solver finished outside a solve");

  // An accepted word always takes the block out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted word left the block idle");

  // Reported positions stay within -1..32767.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.pos_x >= -16'sd1 && out_word.pos_y >= -16'sd1))
    else $error("position out of range");

endmodule
